// ----- design/bts_pkg.sv -----
`timescale 1ns / 1ps
package bts_pkg;

  localparam int PAR_W     = 10;
  localparam int TOK_W     = 16;
  localparam int SCORE_W   = 32;
  localparam int PROB_W    = 16;
  localparam int WIDTH_W   = 4;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam int LN2_Q16 = 45426;

  localparam int BEAM_MAX_DEF       = 8;
  localparam int PARENT_MAX_DEF     = 1024;
  localparam int LOG_TABLE_SIZE_DEF = 256;

  localparam logic [CFG_IDX_W-1:0] CFG_BEAM_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_TOKEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCORES_ACC = 2'd2;

  localparam logic [WIDTH_W-1:0] BEAM_WIDTH_RST = 4'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_SCORE,
    ST_INSERT,
    ST_CHECK,
    ST_RANK,
    ST_ORDER,
    ST_LOAD,
    ST_EMIT
  } bts_state_t;

  typedef struct packed {
    logic capture;
    logic mod_step;
    logic score;
    logic insert;
    logic rank_clr;
    logic rank_step;
    logic order_step;
    logic out_load;
    logic fill_clr;
  } bts_cmd_t;

  typedef struct packed {
    logic is_last;
    logic all_ended;
  } bts_status_t;

endpackage

// ----- design/beam_topk_select.sv -----
`timescale 1ns / 1ps
// beam top-k selection: candidates of one sequence stream in and the best
// beam_width of them are kept in a beam sorted by score, ties broken toward the
// higher parent offset. each candidate passes a capture step (parent_offset is
// reduced modulo PARENT_MAX by a reciprocal multiply on the way in), a step
// that registers the ln table lookup, a score step and an insertion step in
// which all beam cells compare and shift in parallel; the next candidate is
// taken only after the insertion. on the candidate marked last_of_sequence the
// beam is checked, ranked by parent offset, ordered, and then emitted one entry
// at a time, each loaded into the output register and held while the consumer
// keeps sel_stall high. a beam made only of ended parents, or an empty one, is
// dropped at the check. cand_stall stays high during reset. configuration
// writes are always taken (cfg_ready stays high).
module beam_topk_select #(
  parameter int BEAM_MAX       = bts_pkg::BEAM_MAX_DEF,
  parameter int PARENT_MAX     = bts_pkg::PARENT_MAX_DEF,
  parameter int LOG_TABLE_SIZE = bts_pkg::LOG_TABLE_SIZE_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write transaction
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bts_pkg::CFG_W-1:0]          cfg_data,
  // candidate transaction
  input  logic                               cand_valid,
  output logic                               cand_stall,
  input  logic [bts_pkg::PAR_W-1:0]          parent_offset,
  input  logic [bts_pkg::TOK_W-1:0]          parent_token,
  input  logic signed [bts_pkg::SCORE_W-1:0] parent_score,
  input  logic [bts_pkg::TOK_W-1:0]          cand_token,
  input  logic signed [bts_pkg::SCORE_W-1:0] cand_value,
  input  logic                               first_of_parent,
  input  logic                               last_of_sequence,
  // selected entry transaction
  output logic                               sel_valid,
  input  logic                               sel_stall,
  output logic [bts_pkg::TOK_W-1:0]          sel_token,
  output logic signed [bts_pkg::SCORE_W-1:0] sel_score,
  output logic [bts_pkg::PAR_W-1:0]          sel_parent,
  output logic                               sel_last
);
  import bts_pkg::*;

  // fill counter holds up to BEAM_MAX; step counter walks the beam entries
  localparam int FW = $clog2(BEAM_MAX + 1);
  localparam int CW = FW;

  bts_cmd_t      cmd;
  bts_status_t   status;
  logic [FW-1:0] fill;
  logic [CW-1:0] cnt;

  assign cfg_ready = 1'b1;

  // sequencer: owns the candidate and selection handshakes and the step counter
  bts_ctrl #(
    .FW (FW),
    .CW (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cand_valid (cand_valid),
    .cand_stall (cand_stall),
    .sel_valid  (sel_valid),
    .sel_stall  (sel_stall),
    .status     (status),
    .fill       (fill),
    .cmd        (cmd),
    .cnt        (cnt)
  );

  // scoring, beam cells, ranking and output register
  bts_datapath #(
    .BEAM_MAX       (BEAM_MAX),
    .PARENT_MAX     (PARENT_MAX),
    .LOG_TABLE_SIZE (LOG_TABLE_SIZE),
    .FW             (FW),
    .CW             (CW)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .parent_offset    (parent_offset),
    .parent_token     (parent_token),
    .parent_score     (parent_score),
    .cand_token       (cand_token),
    .cand_value       (cand_value),
    .first_of_parent  (first_of_parent),
    .last_of_sequence (last_of_sequence),
    .cmd              (cmd),
    .cnt              (cnt),
    .status           (status),
    .fill             (fill),
    .sel_token        (sel_token),
    .sel_score        (sel_score),
    .sel_parent       (sel_parent),
    .sel_last         (sel_last)
  );

endmodule

// ----- design/bts_ctrl.sv -----
`timescale 1ns / 1ps
module bts_ctrl #(
  parameter int FW = 4,
  parameter int CW = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cand_valid,
  output logic                 cand_stall,
  output logic                 sel_valid,
  input  logic                 sel_stall,
  input  bts_pkg::bts_status_t status,
  input  logic [FW-1:0]        fill,
  output bts_pkg::bts_cmd_t    cmd,
  output logic [CW-1:0]        cnt
);
  import bts_pkg::*;

  bts_state_t    state, state_next;
  logic [CW-1:0] cnt_next;
  logic [CW-1:0] fill_m1;

  assign fill_m1 = CW'(fill) - CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cand_stall = 1'b1;
    sel_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cand_stall = rst;
        if (cand_valid && !rst) begin
          cmd.capture = 1'b1;
          cnt_next    = '0;
          state_next  = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        state_next   = ST_SCORE;
      end
      ST_SCORE: begin
        cmd.score  = 1'b1;
        state_next = ST_INSERT;
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
        state_next = status.is_last ? ST_CHECK : ST_IDLE;
      end
      ST_CHECK: begin
        cnt_next = '0;
        if (fill == '0 || status.all_ended) begin
          cmd.fill_clr = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          cmd.rank_clr = 1'b1;
          state_next   = ST_RANK;
        end
      end
      ST_RANK: begin
        cmd.rank_step = 1'b1;
        cnt_next      = cnt + CW'(1);
        if (cnt == fill_m1) begin
          cnt_next   = '0;
          state_next = ST_ORDER;
        end
      end
      ST_ORDER: begin
        cmd.order_step = 1'b1;
        cnt_next       = cnt + CW'(1);
        if (cnt == fill_m1) begin
          cnt_next   = '0;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.out_load = 1'b1;
        state_next   = ST_EMIT;
      end
      ST_EMIT: begin
        sel_valid = 1'b1;
        if (!sel_stall) begin
          if (cnt == fill_m1) begin
            cmd.fill_clr = 1'b1;
            state_next   = ST_IDLE;
          end else begin
            cnt_next   = cnt + CW'(1);
            state_next = ST_LOAD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- design/bts_datapath.sv -----
`timescale 1ns / 1ps
module bts_datapath #(
  parameter int BEAM_MAX       = 8,
  parameter int PARENT_MAX     = 1024,
  parameter int LOG_TABLE_SIZE = 256,
  parameter int FW             = 4,
  parameter int CW             = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [bts_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bts_pkg::CFG_W-1:0]           cfg_data,
  input  logic [bts_pkg::PAR_W-1:0]           parent_offset,
  input  logic [bts_pkg::TOK_W-1:0]           parent_token,
  input  logic signed [bts_pkg::SCORE_W-1:0]  parent_score,
  input  logic [bts_pkg::TOK_W-1:0]           cand_token,
  input  logic signed [bts_pkg::SCORE_W-1:0]  cand_value,
  input  logic                                first_of_parent,
  input  logic                                last_of_sequence,
  input  bts_pkg::bts_cmd_t                   cmd,
  input  logic [CW-1:0]                       cnt,
  output bts_pkg::bts_status_t                status,
  output logic [FW-1:0]                       fill,
  output logic [bts_pkg::TOK_W-1:0]           sel_token,
  output logic signed [bts_pkg::SCORE_W-1:0]  sel_score,
  output logic [bts_pkg::PAR_W-1:0]           sel_parent,
  output logic                                sel_last
);
  import bts_pkg::*;

  localparam int IW   = (BEAM_MAX > 1) ? $clog2(BEAM_MAX) : 1;
  localparam int LW   = $clog2(LOG_TABLE_SIZE);
  localparam int CMPW = ((FW > WIDTH_W) ? FW : WIDTH_W) + 1;
  localparam int LN_W = 21;

  // reciprocal for the parent offset remainder
  localparam int     RL  = $clog2(PARENT_MAX);
  localparam int     RSH = PAR_W + RL;
  localparam longint RM  = ((longint'(1) << RSH) + longint'(PARENT_MAX) - 1)
                           / longint'(PARENT_MAX);

  // configuration
  logic [WIDTH_W-1:0] beam_width;
  logic [TOK_W-1:0]   end_token;
  logic               scores_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      beam_width <= BEAM_WIDTH_RST;
      end_token  <= '0;
      scores_acc <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BEAM_WIDTH: beam_width <= cfg_data[WIDTH_W-1:0];
        CFG_END_TOKEN:  end_token  <= cfg_data[TOK_W-1:0];
        CFG_SCORES_ACC: scores_acc <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [CMPW-1:0] w_ext;
  logic [FW-1:0]   w_eff;
  assign w_ext = CMPW'(beam_width);
  always_comb begin
    if (w_ext == '0) w_eff = FW'(1);
    else if (w_ext > CMPW'(BEAM_MAX)) w_eff = FW'(BEAM_MAX);
    else w_eff = w_ext[FW-1:0];
  end

  // captured item
  logic [PAR_W-1:0]          par_r;
  logic [TOK_W-1:0]          ptok_r, ctok_r;
  logic signed [SCORE_W-1:0] pscore_r, cval_r;
  logic                      first_r, last_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ptok_r   <= parent_token;
      pscore_r <= parent_score;
      ctok_r   <= cand_token;
      cval_r   <= cand_value;
      first_r  <= first_of_parent;
      last_r   <= last_of_sequence;
    end
  end

  // parent offset remainder: quotient by reciprocal multiply, then subtract
  logic [31:0] mod_prod;
  logic [31:0] mod_quo;
  logic [31:0] mod_rem;
  assign mod_prod = 32'(parent_offset) * 32'(RM);
  assign mod_quo  = mod_prod >> RSH;
  assign mod_rem  = 32'(parent_offset) - mod_quo * 32'(PARENT_MAX);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      par_r <= mod_rem[PAR_W-1:0];
    end
  end

  // ln table, ln(1 + i/N) in q0.16 from a 2*atanh series
  logic [15:0] log_tab [LOG_TABLE_SIZE];

  for (genvar gi = 0; gi < LOG_TABLE_SIZE; gi++) begin : g_tab
    localparam logic [63:0] Z   = (64'(gi) << 32) / (64'(2 * LOG_TABLE_SIZE) + 64'(gi));
    localparam logic [63:0] Z2  = (Z * Z) >> 32;
    localparam logic [63:0] T1  = Z;
    localparam logic [63:0] T3  = (T1 * Z2) >> 32;
    localparam logic [63:0] T5  = (T3 * Z2) >> 32;
    localparam logic [63:0] T7  = (T5 * Z2) >> 32;
    localparam logic [63:0] T9  = (T7 * Z2) >> 32;
    localparam logic [63:0] T11 = (T9 * Z2) >> 32;
    localparam logic [63:0] T13 = (T11 * Z2) >> 32;
    localparam logic [63:0] T15 = (T13 * Z2) >> 32;
    localparam logic [63:0] T17 = (T15 * Z2) >> 32;
    localparam logic [63:0] T19 = (T17 * Z2) >> 32;
    localparam logic [63:0] T21 = (T19 * Z2) >> 32;
    localparam logic [63:0] T23 = (T21 * Z2) >> 32;
    localparam logic [63:0] T25 = (T23 * Z2) >> 32;
    localparam logic [63:0] T27 = (T25 * Z2) >> 32;
    localparam logic [63:0] T29 = (T27 * Z2) >> 32;
    localparam logic [63:0] T31 = (T29 * Z2) >> 32;
    localparam logic [63:0] SUM = T1 + T3 / 3 + T5 / 5 + T7 / 7 + T9 / 9 + T11 / 11
                                + T13 / 13 + T15 / 15 + T17 / 17 + T19 / 19 + T21 / 21
                                + T23 / 23 + T25 / 25 + T27 / 27 + T29 / 29 + T31 / 31;
    localparam logic [63:0] VAL = (2 * SUM + 64'd32768) >> 16;
    assign log_tab[gi] = VAL[15:0];
  end

  // ln of the probability
  logic [PROB_W-1:0]      prob;
  logic [3:0]             lead;
  logic [PROB_W-1:0]      norm;
  logic [PROB_W-1:0]      frac;
  logic [31:0]            idx_prod;
  logic [LW-1:0]          tab_idx;
  logic [4:0]             oct;
  logic [19:0]            oct_ln;
  logic signed [LN_W-1:0] ln_val, ln_r;

  assign prob = cval_r[PROB_W-1:0];

  always_comb begin
    lead = '0;
    for (int i = 0; i < PROB_W; i++) begin
      if (prob[i]) lead = 4'(i);
    end
  end

  assign norm     = prob << (4'd15 - lead);
  assign frac     = {norm[PROB_W-2:0], 1'b0};
  assign idx_prod = 32'(frac) * 32'(LOG_TABLE_SIZE);
  assign tab_idx  = idx_prod[16 +: LW];
  assign oct      = 5'd16 - 5'(lead);
  assign oct_ln   = 20'(oct) * 20'(LN2_Q16);
  assign ln_val   = $signed({5'd0, log_tab[tab_idx]}) - $signed({1'b0, oct_ln});

  always_ff @(posedge clk) begin
    if (cmd.mod_step) ln_r <= ln_val;
  end

  // score of the new entry
  logic signed [SCORE_W:0]   sum_ext;
  logic signed [SCORE_W-1:0] sum_sat;
  logic                      ended;
  logic signed [SCORE_W-1:0] score_r;
  logic [TOK_W-1:0]          tok_new;
  logic                      ended_new, ins_en;

  assign sum_ext = (SCORE_W + 1)'(pscore_r) + (SCORE_W + 1)'(ln_r);
  always_comb begin
    if (sum_ext[SCORE_W] != sum_ext[SCORE_W-1])
      sum_sat = sum_ext[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
    else
      sum_sat = sum_ext[SCORE_W-1:0];
  end

  assign ended = (ptok_r == end_token);

  always_ff @(posedge clk) begin
    if (cmd.score) begin
      ended_new <= ended;
      ins_en    <= !ended || first_r;
      tok_new   <= ended ? end_token : ctok_r;
      if (ended) score_r <= pscore_r;
      else if (scores_acc) score_r <= cval_r;
      else if (prob == '0) score_r <= {1'b1, {(SCORE_W-1){1'b0}}};
      else score_r <= sum_sat;
    end
  end

  // beam cells
  logic signed [SCORE_W-1:0] beam_score  [BEAM_MAX];
  logic [TOK_W-1:0]          beam_token  [BEAM_MAX];
  logic [PAR_W-1:0]          beam_parent [BEAM_MAX];
  logic [BEAM_MAX-1:0]       beam_ended;
  logic [IW-1:0]             rank        [BEAM_MAX];
  logic [IW-1:0]             order       [BEAM_MAX];

  logic [FW-1:0]       fill_c;
  logic [BEAM_MAX-1:0] below, take_new, slot_live, slot_valid;
  logic                insert_go;
  logic [IW-1:0]       idx;
  logic [PAR_W-1:0]    bcast_par;

  assign fill_c    = (fill > w_eff) ? w_eff : fill;
  assign insert_go = cmd.insert && ins_en;
  assign idx       = cnt[IW-1:0];
  assign bcast_par = beam_parent[idx];

  for (genvar gk = 0; gk < BEAM_MAX; gk++) begin : g_cell
    localparam logic [FW-1:0] KF = FW'(gk);
    localparam logic [IW-1:0] KI = IW'(gk);
    logic e_below_new, new_below_e, last_slot;

    assign slot_valid[gk] = KF < fill_c;
    assign slot_live[gk]  = KF < w_eff;
    assign last_slot      = (KF == w_eff - FW'(1));
    assign e_below_new = (beam_score[gk] < score_r) ||
                         (beam_score[gk] == score_r && beam_parent[gk] < par_r);
    assign new_below_e = (score_r < beam_score[gk]) ||
                         (score_r == beam_score[gk] && par_r < beam_parent[gk]);
    assign below[gk] = !slot_valid[gk] || (last_slot ? !new_below_e : e_below_new);

    if (gk == 0) begin : g_head
      assign take_new[gk] = below[gk];
      always_ff @(posedge clk) begin
        if (insert_go && slot_live[gk] && below[gk]) begin
          beam_score[gk]  <= score_r;
          beam_token[gk]  <= tok_new;
          beam_parent[gk] <= par_r;
          beam_ended[gk]  <= ended_new;
        end
      end
    end else begin : g_body
      assign take_new[gk] = below[gk] && !below[gk-1];
      always_ff @(posedge clk) begin
        if (insert_go && slot_live[gk] && below[gk]) begin
          if (take_new[gk]) begin
            beam_score[gk]  <= score_r;
            beam_token[gk]  <= tok_new;
            beam_parent[gk] <= par_r;
            beam_ended[gk]  <= ended_new;
          end else begin
            beam_score[gk]  <= beam_score[gk-1];
            beam_token[gk]  <= beam_token[gk-1];
            beam_parent[gk] <= beam_parent[gk-1];
            beam_ended[gk]  <= beam_ended[gk-1];
          end
        end
      end
    end

    // stable rank by parent offset
    always_ff @(posedge clk) begin
      if (cmd.rank_clr) begin
        rank[gk] <= '0;
      end else if (cmd.rank_step) begin
        if ((bcast_par < beam_parent[gk]) || (bcast_par == beam_parent[gk] && idx < KI))
          rank[gk] <= rank[gk] + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.fill_clr) begin
      fill <= '0;
    end else if (insert_go) begin
      fill <= (fill_c < w_eff) ? fill_c + FW'(1) : fill_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.order_step) order[rank[idx]] <= idx;
  end

  logic [IW-1:0] pick;
  assign pick = order[idx];

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      sel_token  <= beam_token[pick];
      sel_score  <= beam_score[pick];
      sel_parent <= beam_parent[pick];
      sel_last   <= (cnt == CW'(fill) - CW'(1));
    end
  end

  always_comb begin
    status.is_last   = last_r;
    status.all_ended = 1'b1;
    for (int k = 0; k < BEAM_MAX; k++) begin
      if (FW'(k) < fill && !beam_ended[k]) status.all_ended = 1'b0;
    end
  end

endmodule
